// ===== hw/rtl/crlu_pkg.sv =====
// ----------------------------------------------------------------------------
// crlu_pkg: shared types and constants of the channel RLE unpacker
// Register indexes, decoder phases, field widths and default limits.
// ----------------------------------------------------------------------------
`default_nettype none

package crlu_pkg;

   // Default geometry limits, handed to the top level as parameter defaults.
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int MAX_STRIDE_DEF = 4;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int WIDTH_REG_W  = 13;
   localparam int HEIGHT_REG_W = 13;
   localparam int STRIDE_REG_W = 3;
   localparam int OFFSET_W     = 2;

   // Beat fields.
   localparam int DATA_W  = 8;
   localparam int ADDR_W  = 26;
   localparam int LEN_W   = 7;
   localparam int RUN_W   = 8;
   localparam int PAD_W   = 2;

   // A count byte above this value announces a repeated run.
   localparam logic [DATA_W-1:0] RLE_BIAS = 8'd128;
   // Raw rows are padded to a multiple of this many bytes.
   localparam int ROW_ALIGN = 4;

   localparam logic MODE_RAW = 1'b0;
   localparam logic MODE_RLE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MODE   = 3'd0,
      REG_WIDTH  = 3'd1,
      REG_HEIGHT = 3'd2,
      REG_STRIDE = 3'd3,
      REG_OFFSET = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_COUNT   = 2'd0,
      PH_REPEAT  = 2'd1,
      PH_LITERAL = 2'd2
   } phase_type;

   // Register reset values.
   localparam logic                    MODE_RESET   = MODE_RLE;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd1;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1;
   localparam logic [STRIDE_REG_W-1:0] STRIDE_RESET = 3'd1;
   localparam logic [OFFSET_W-1:0]     OFFSET_RESET = 2'd0;

endpackage

`default_nettype wire

// ===== hw/rtl/crlu_req_if.sv =====
// ----------------------------------------------------------------------------
// crlu_req_if: input byte channel
// Valid/ready channel carrying one stored channel byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface crlu_req_if;
   logic                        valid;
   logic                        ready;
   logic [crlu_pkg::DATA_W-1:0] data_byte;
   logic                        start_channel;

   modport source (output valid, output data_byte, output start_channel, input ready);
   modport sink   (input valid, input data_byte, input start_channel, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/crlu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// crlu_rsp_if: run descriptor channel
// Valid/ready channel carrying one pixel-store run per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface crlu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [crlu_pkg::ADDR_W-1:0] write_address;
   logic [crlu_pkg::DATA_W-1:0] write_value;
   logic [crlu_pkg::LEN_W-1:0]  run_length;
   logic                        channel_done;

   modport source (output valid, output write_address, output write_value,
                   output run_length, output channel_done, input ready);
   modport sink   (input valid, input write_address, input write_value,
                   input run_length, input channel_done, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/crlu_csr.sv =====
// ----------------------------------------------------------------------------
// crlu_csr: configuration registers and derived geometry
// Holds the five registers and registers the clamped width, stride, row
// padding and pixel total that the decoder uses.
// ----------------------------------------------------------------------------
`default_nettype none

module crlu_csr #(
   parameter int MAX_WIDTH  = crlu_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = crlu_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_STRIDE = crlu_pkg::MAX_STRIDE_DEF,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1),
   localparam int SW = $clog2(MAX_STRIDE + 1),
   localparam int PW = $clog2(longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) + 64'd1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_en,
   input  wire logic [crlu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [crlu_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                                  mode,
   output logic [crlu_pkg::OFFSET_W-1:0]         offset,
   output logic [WW-1:0]                         width_eff,
   output logic [SW-1:0]                         stride_eff,
   output logic [crlu_pkg::PAD_W-1:0]            pad_count,
   output logic [PW-1:0]                         total
);

   // A one-pixel row needs three bytes of padding.
   localparam int ROW_PAD_RESET = crlu_pkg::ROW_ALIGN - 1;

   logic                                  mode_ff, mode_in;
   logic [crlu_pkg::WIDTH_REG_W-1:0]      width_ff, width_in;
   logic [crlu_pkg::HEIGHT_REG_W-1:0]     height_ff, height_in;
   logic [crlu_pkg::STRIDE_REG_W-1:0]     stride_ff, stride_in;
   logic [crlu_pkg::OFFSET_W-1:0]         offset_ff, offset_in;

   logic [WW-1:0]                         width_eff_ff, width_eff_in;
   logic [HW-1:0]                         height_eff;
   logic [SW-1:0]                         stride_eff_ff, stride_eff_in;
   logic [crlu_pkg::PAD_W-1:0]            pad_ff, pad_in;
   logic [PW-1:0]                         total_ff, total_in;

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      stride_in = stride_ff;
      offset_in = offset_ff;
      if (csr_write_en) begin
         unique case (crlu_pkg::csr_index_type'(csr_index))
            crlu_pkg::REG_MODE:   mode_in   = csr_data[0];
            crlu_pkg::REG_WIDTH:  width_in  = csr_data[crlu_pkg::WIDTH_REG_W-1:0];
            crlu_pkg::REG_HEIGHT: height_in = csr_data[crlu_pkg::HEIGHT_REG_W-1:0];
            crlu_pkg::REG_STRIDE: stride_in = csr_data[crlu_pkg::STRIDE_REG_W-1:0];
            crlu_pkg::REG_OFFSET: offset_in = csr_data[crlu_pkg::OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero acts as one and large values saturate at the parameter limits.
   always_comb begin
      if (width_ff == '0) begin
         width_eff_in = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_eff_in = WW'(MAX_WIDTH);
      end else begin
         width_eff_in = WW'(width_ff);
      end

      if (height_ff == '0) begin
         height_eff = HW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = HW'(height_ff);
      end

      if (stride_ff == '0) begin
         stride_eff_in = SW'(1);
      end else if (32'(stride_ff) > 32'(MAX_STRIDE)) begin
         stride_eff_in = SW'(MAX_STRIDE);
      end else begin
         stride_eff_in = SW'(stride_ff);
      end

      total_in = PW'(PW'(width_eff_in) * PW'(height_eff));
      // Bytes needed to bring a row up to the next multiple of four.
      pad_in   = crlu_pkg::PAD_W'(-width_eff_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= crlu_pkg::MODE_RESET;
         width_ff  <= crlu_pkg::WIDTH_RESET;
         height_ff <= crlu_pkg::HEIGHT_RESET;
         stride_ff <= crlu_pkg::STRIDE_RESET;
         offset_ff <= crlu_pkg::OFFSET_RESET;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         stride_ff <= stride_in;
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_eff_ff  <= WW'(1);
         stride_eff_ff <= SW'(1);
         pad_ff        <= crlu_pkg::PAD_W'(ROW_PAD_RESET);
         total_ff      <= PW'(1);
      end else begin
         width_eff_ff  <= width_eff_in;
         stride_eff_ff <= stride_eff_in;
         pad_ff        <= pad_in;
         total_ff      <= total_in;
      end
   end

   assign mode       = mode_ff;
   assign offset     = offset_ff;
   assign width_eff  = width_eff_ff;
   assign stride_eff = stride_eff_ff;
   assign pad_count  = pad_ff;
   assign total      = total_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/channel_rle_unpacker_core.sv =====
// ----------------------------------------------------------------------------
// channel_rle_unpacker_core: planar channel RLE unpacker
// Turns stored channel bytes into run descriptors for an interleaved store.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one stored byte per beat; start_channel on a beat clears
//   the counters before that byte is decoded. rsp_chan carries zero or one
//   run (address, value, length, done flag) for each byte. Count bytes,
//   padding bytes and bytes after the last pixel give no run.
//   The csr_ port writes the five registers; write it only while idle.
//   An accepted byte waits in the input register until the result register
//   can take it, then its run is registered there and offered on rsp_chan.
//   Throughput: one byte per cycle while the receiver does not stall, limited
//   by the single decode step between the two registers.
//   A stalled receiver holds the result register; the input register still
//   takes one more byte, then req_chan.ready drops until the result drains.
//   Reset clears both registers stages, the decoder to expect a count byte,
//   all counters to zero and the registers to RLE mode, a 1x1 channel,
//   stride one and offset zero.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_rle_unpacker_core #(
   parameter int MAX_WIDTH  = crlu_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = crlu_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_STRIDE = crlu_pkg::MAX_STRIDE_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   crlu_req_if.sink                              req_chan,
   crlu_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_write_en,
   input  wire logic [crlu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [crlu_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int SW = $clog2(MAX_STRIDE + 1);
   localparam int PW = $clog2(longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) + 64'd1);
   localparam int AW = crlu_pkg::ADDR_W;
   localparam int RW = crlu_pkg::RUN_W;

   // Geometry.
   logic                          cfg_mode;
   logic [crlu_pkg::OFFSET_W-1:0] cfg_offset;
   logic [WW-1:0]                 cfg_width;
   logic [SW-1:0]                 cfg_stride;
   logic [crlu_pkg::PAD_W-1:0]    cfg_pad;
   logic [PW-1:0]                 cfg_total;

   crlu_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_STRIDE (MAX_STRIDE)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .mode         (cfg_mode),
      .offset       (cfg_offset),
      .width_eff    (cfg_width),
      .stride_eff   (cfg_stride),
      .pad_count    (cfg_pad),
      .total        (cfg_total)
   );

   // Pipeline handshake.
   logic                        in_valid_ff, in_valid_in;
   logic [crlu_pkg::DATA_W-1:0] in_data_ff, in_data_in;
   logic                        in_start_ff, in_start_in;
   logic                        out_valid_ff, out_valid_in;
   logic [AW-1:0]               out_addr_ff, out_addr_in;
   logic [crlu_pkg::DATA_W-1:0] out_value_ff, out_value_in;
   logic [crlu_pkg::LEN_W-1:0]  out_len_ff, out_len_in;
   logic                        out_done_ff, out_done_in;

   logic can_move;
   logic take;
   logic step;

   // Decoder state.
   crlu_pkg::phase_type        phase_ff, phase_in;
   logic [RW-1:0]              run_ff, run_in;
   logic [PW-1:0]              pw_ff, pw_in;
   logic [CW-1:0]              col_ff, col_in;
   logic [crlu_pkg::PAD_W-1:0] pad_ff, pad_in;
   logic [AW-1:0]              addr_ff, addr_in;

   // State as seen by the byte in the input register, after a channel start.
   crlu_pkg::phase_type        eff_phase;
   logic [RW-1:0]              eff_run;
   logic [PW-1:0]              eff_pw;
   logic [CW-1:0]              eff_col;
   logic [crlu_pkg::PAD_W-1:0] eff_pad;
   logic [AW-1:0]              eff_addr;

   logic                       full;
   logic [PW-1:0]              left;
   logic [RW-1:0]              run_dec;
   logic [CW:0]                col_inc;
   logic [RW-1:0]              want;
   logic [RW-1:0]              len;
   logic                       emit;
   logic [PW-1:0]              pw_new;
   logic [AW-1:0]              addr_new;

   assign can_move       = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || can_move;
   assign take           = req_chan.valid && req_chan.ready;
   assign step           = in_valid_ff && can_move;

   always_comb begin
      if (in_start_ff) begin
         eff_phase = crlu_pkg::PH_COUNT;
         eff_run   = '0;
         eff_pw    = '0;
         eff_col   = '0;
         eff_pad   = '0;
         eff_addr  = AW'(cfg_offset);
      end else begin
         eff_phase = phase_ff;
         eff_run   = run_ff;
         eff_pw    = pw_ff;
         eff_col   = col_ff;
         eff_pad   = pad_ff;
         eff_addr  = addr_ff;
      end
   end

   assign full    = eff_pw >= cfg_total;
   assign left    = cfg_total - eff_pw;
   assign run_dec = (eff_run != '0) ? eff_run - RW'(1) : '0;
   assign col_inc = {1'b0, eff_col} + (CW+1)'(1);

   // Next phase of the count/value decoder.
   always_comb begin
      phase_in = eff_phase;
      if (!full && cfg_mode == crlu_pkg::MODE_RLE) begin
         unique case (eff_phase)
            crlu_pkg::PH_REPEAT: begin
               phase_in = crlu_pkg::PH_COUNT;
            end
            crlu_pkg::PH_LITERAL: begin
               if (run_dec == '0) begin
                  phase_in = crlu_pkg::PH_COUNT;
               end
            end
            default: begin
               if (in_data_ff > crlu_pkg::RLE_BIAS) begin
                  phase_in = crlu_pkg::PH_REPEAT;
               end else if (in_data_ff != '0) begin
                  phase_in = crlu_pkg::PH_LITERAL;
               end else begin
                  phase_in = crlu_pkg::PH_COUNT;
               end
            end
         endcase
      end
   end

   // Run request and counter updates for the byte in the input register.
   always_comb begin
      run_in = eff_run;
      col_in = eff_col;
      pad_in = eff_pad;
      want   = '0;
      if (!full) begin
         if (cfg_mode == crlu_pkg::MODE_RAW) begin
            if (eff_pad != '0) begin
               pad_in = eff_pad - crlu_pkg::PAD_W'(1);
            end else begin
               want = RW'(1);
               if (32'(col_inc) >= 32'(cfg_width)) begin
                  col_in = '0;
                  pad_in = cfg_pad;
               end else begin
                  col_in = col_inc[CW-1:0];
               end
            end
         end else begin
            unique case (eff_phase)
               crlu_pkg::PH_REPEAT: begin
                  want = eff_run;
               end
               crlu_pkg::PH_LITERAL: begin
                  run_in = run_dec;
                  want   = RW'(1);
               end
               default: begin
                  if (in_data_ff > crlu_pkg::RLE_BIAS) begin
                     run_in = in_data_ff - crlu_pkg::RLE_BIAS;
                  end else begin
                     run_in = in_data_ff;
                  end
               end
            endcase
         end
      end
   end

   // Clamp the run to the pixels left in the channel.
   always_comb begin
      if (PW'(want) < left) begin
         len = want;
      end else begin
         len = RW'(left);
      end
      emit     = (want != '0);
      pw_new   = eff_pw + PW'(len);
      addr_new = eff_addr + AW'(AW'(len) * AW'(cfg_stride));
      pw_in    = emit ? pw_new : eff_pw;
      addr_in  = emit ? addr_new : eff_addr;
   end

   // Input and result registers.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_start_in = in_start_ff;
      if (take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_chan.data_byte;
         in_start_in = req_chan.start_channel;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_value_in = out_value_ff;
      out_len_in   = out_len_ff;
      out_done_in  = out_done_ff;
      if (step) begin
         out_valid_in = emit;
         if (emit) begin
            out_addr_in  = eff_addr;
            out_value_in = in_data_ff;
            out_len_in   = crlu_pkg::LEN_W'(len);
            out_done_in  = pw_new >= cfg_total;
         end
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= crlu_pkg::PH_COUNT;
         run_ff       <= '0;
         pw_ff        <= '0;
         col_ff       <= '0;
         pad_ff       <= '0;
         addr_ff      <= AW'(crlu_pkg::OFFSET_RESET);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            phase_ff <= phase_in;
            run_ff   <= run_in;
            pw_ff    <= pw_in;
            col_ff   <= col_in;
            pad_ff   <= pad_in;
            addr_ff  <= addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff   <= in_data_in;
      in_start_ff  <= in_start_in;
      out_addr_ff  <= out_addr_in;
      out_value_ff <= out_value_in;
      out_len_ff   <= out_len_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.write_address = out_addr_ff;
   assign rsp_chan.write_value   = out_value_ff;
   assign rsp_chan.run_length    = out_len_ff;
   assign rsp_chan.channel_done  = out_done_ff;

   // A run beat never carries zero pixels.
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_len_ff != '0)
      else $error("run beat with zero length");

   // A repeat or literal phase always has pixels still owed.
   a_run_owed: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == crlu_pkg::PH_REPEAT || phase_ff == crlu_pkg::PH_LITERAL)
      |-> run_ff != '0)
      else $error("decoder phase without a pending run");

   // A repeated run never exceeds 127 pixels.
   a_repeat_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == crlu_pkg::PH_REPEAT |-> run_ff < RW'(crlu_pkg::RLE_BIAS))
      else $error("repeat run too long");

   // A byte held behind a stalled result stays in the input register.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !can_move |=> in_valid_ff && $stable(in_data_ff))
      else $error("input byte lost during stall");

endmodule

`default_nettype wire

// ===== tb/run_descriptor_check.sv =====
// ----------------------------------------------------------------------------
// run_descriptor_check: run predictor and comparator for the RLE unpacker
// Watches the register port and both channels, decodes every accepted byte
// into the run it should produce, and compares each run beat in order.
// ----------------------------------------------------------------------------

module run_descriptor_check (
   input  logic                             clock,
   input  logic                             reset,
   crlu_req_if                              req_chan,
   crlu_rsp_if                              rsp_chan,
   input  logic                             csr_write_en,
   input  logic [crlu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [crlu_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               mismatch_count,
   output int                               pending_runs
);

   typedef struct packed {
      logic [crlu_pkg::ADDR_W-1:0] addr;
      logic [crlu_pkg::DATA_W-1:0] value;
      logic [crlu_pkg::LEN_W-1:0]  len;
      logic                        done;
   } pixel_run_type;

   // Register copies.
   logic                              cfg_mode;
   logic [crlu_pkg::WIDTH_REG_W-1:0]  cfg_width;
   logic [crlu_pkg::HEIGHT_REG_W-1:0] cfg_height;
   logic [crlu_pkg::STRIDE_REG_W-1:0] cfg_stride;
   logic [crlu_pkg::OFFSET_W-1:0]     cfg_offset;

   // Decoder state of the channel being unpacked.
   crlu_pkg::phase_type         dec_phase;
   logic [crlu_pkg::RUN_W-1:0]  run_left;
   logic [24:0]                 filled;
   logic [12:0]                 col;
   logic [crlu_pkg::PAD_W-1:0]  pad_left;
   logic [crlu_pkg::ADDR_W-1:0] next_addr;

   pixel_run_type runs_due[$];

   function automatic int clamp_dim(input int v, input int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void restart_channel();
      dec_phase = crlu_pkg::PH_COUNT;
      run_left  = '0;
      filled    = '0;
      col       = '0;
      pad_left  = '0;
      next_addr = crlu_pkg::ADDR_W'(cfg_offset);
   endfunction

   // Places a run of up to want pixels, clamped to what is left of the channel.
   function automatic logic place_run(input logic [crlu_pkg::DATA_W-1:0] value,
                                      input int want, input int total,
                                      input int stride, output pixel_run_type r);
      int left;
      int len;
      left = total - int'(filled);
      len  = (want < left) ? want : left;
      r    = '0;
      if (len <= 0) return 1'b0;
      r.addr    = next_addr;
      r.value   = value;
      r.len     = crlu_pkg::LEN_W'(len);
      filled    = filled + 25'(len);
      r.done    = (int'(filled) >= total);
      next_addr = next_addr + crlu_pkg::ADDR_W'(len * stride);
      return 1'b1;
   endfunction

   function automatic logic decode_byte(input logic [crlu_pkg::DATA_W-1:0] b,
                                        input logic st, output pixel_run_type r);
      int w;
      int h;
      int stride;
      int total;
      logic hit;
      w      = clamp_dim(int'(cfg_width), crlu_pkg::MAX_WIDTH_DEF);
      h      = clamp_dim(int'(cfg_height), crlu_pkg::MAX_HEIGHT_DEF);
      stride = clamp_dim(int'(cfg_stride), crlu_pkg::MAX_STRIDE_DEF);
      total  = w * h;
      r      = '0;
      if (st) restart_channel();
      if (int'(filled) >= total) return 1'b0;

      if (cfg_mode == crlu_pkg::MODE_RAW) begin
         if (pad_left != 0) begin
            pad_left = pad_left - crlu_pkg::PAD_W'(1);
            return 1'b0;
         end
         hit = place_run(b, 1, total, stride, r);
         col = col + 13'(1);
         if (int'(col) >= w) begin
            col      = '0;
            pad_left = crlu_pkg::PAD_W'(crlu_pkg::ROW_ALIGN - (w % crlu_pkg::ROW_ALIGN));
         end
         return hit;
      end

      case (dec_phase)
         crlu_pkg::PH_REPEAT: begin
            dec_phase = crlu_pkg::PH_COUNT;
            return place_run(b, int'(run_left), total, stride, r);
         end
         crlu_pkg::PH_LITERAL: begin
            if (run_left != 0) run_left = run_left - crlu_pkg::RUN_W'(1);
            if (run_left == 0) dec_phase = crlu_pkg::PH_COUNT;
            return place_run(b, 1, total, stride, r);
         end
         default: begin
            if (b > crlu_pkg::RLE_BIAS) begin
               run_left  = b - crlu_pkg::RLE_BIAS;
               dec_phase = crlu_pkg::PH_REPEAT;
            end else if (b != 0) begin
               run_left  = b;
               dec_phase = crlu_pkg::PH_LITERAL;
            end else begin
               run_left  = '0;
               dec_phase = crlu_pkg::PH_COUNT;
            end
            return 1'b0;
         end
      endcase
   endfunction

   task automatic log_mismatch(input string what, input pixel_run_type want,
                               input pixel_run_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t run beat %s: expected addr=%h value=%h len=%0d done=%b",
                  $realtime, what, want.addr, want.value, want.len, want.done);
         $display("%0t run beat %s: got      addr=%h value=%h len=%0d done=%b",
                  $realtime, what, got.addr, got.value, got.len, got.done);
      end
   endtask

   always @(posedge clock) begin : watch
      pixel_run_type fresh_run;
      pixel_run_type due;
      pixel_run_type seen;
      if (reset) begin
         cfg_mode       = crlu_pkg::MODE_RESET;
         cfg_width      = crlu_pkg::WIDTH_RESET;
         cfg_height     = crlu_pkg::HEIGHT_RESET;
         cfg_stride     = crlu_pkg::STRIDE_RESET;
         cfg_offset     = crlu_pkg::OFFSET_RESET;
         mismatch_count = 0;
         restart_channel();
         runs_due.delete();
      end else begin
         if (csr_write_en) begin
            case (crlu_pkg::csr_index_type'(csr_index))
               crlu_pkg::REG_MODE:   cfg_mode   = csr_data[0];
               crlu_pkg::REG_WIDTH:  cfg_width  = csr_data[crlu_pkg::WIDTH_REG_W-1:0];
               crlu_pkg::REG_HEIGHT: cfg_height = csr_data[crlu_pkg::HEIGHT_REG_W-1:0];
               crlu_pkg::REG_STRIDE: cfg_stride = csr_data[crlu_pkg::STRIDE_REG_W-1:0];
               crlu_pkg::REG_OFFSET: cfg_offset = csr_data[crlu_pkg::OFFSET_W-1:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            if (decode_byte(req_chan.data_byte, req_chan.start_channel, fresh_run))
               runs_due.push_back(fresh_run);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.addr  = rsp_chan.write_address;
            seen.value = rsp_chan.write_value;
            seen.len   = rsp_chan.run_length;
            seen.done  = rsp_chan.channel_done;
            if (runs_due.size() == 0) begin
               log_mismatch("with nothing expected", '0, seen);
            end else begin
               due = runs_due.pop_front();
               if (seen.addr !== due.addr || seen.value !== due.value ||
                   seen.len !== due.len || seen.done !== due.done)
                  log_mismatch("differs", due, seen);
            end
         end
      end
      pending_runs = runs_due.size();
   end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top of the channel RLE unpacker
// Drives register settings and byte streams (directed corner cases, then
// random run-length and raw channels with random stalls on both channels);
// the run descriptor checker predicts and compares every run beat.
// ----------------------------------------------------------------------------

module tb;

   logic                             clock;
   logic                             reset;
   logic                             csr_write_en;
   logic [crlu_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [crlu_pkg::CSR_DATA_W-1:0]  csr_data;
   int                               mismatch_count;
   int                               pending_runs;

   // When set, neither side inserts gaps or stalls.
   logic calm;
   int   sent;
   // Current register settings, as written.
   int   cur_mode;
   int   cur_w;
   int   cur_h;
   // Stream generation bookkeeping for the running phase.
   logic lead_pending;
   int   phase_bytes;

   crlu_req_if req_chan ();
   crlu_rsp_if rsp_chan ();

   channel_rle_unpacker_core uut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   run_descriptor_check run_check (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_runs   (pending_runs)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #6000000;
      $display("FAIL channel_rle_unpacker_core");
      $finish;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 33);
      end
   end

   function automatic int eff_dim(input int v);
      if (v == 0) return 1;
      return (v > crlu_pkg::MAX_WIDTH_DEF) ? crlu_pkg::MAX_WIDTH_DEF : v;
   endfunction

   function automatic int extreme_dim();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 1;
         2:       return crlu_pkg::MAX_WIDTH_DEF;
         default: return 2 ** crlu_pkg::WIDTH_REG_W - 1;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_byte(input logic [crlu_pkg::DATA_W-1:0] b, input logic st);
      while (!calm && $urandom_range(0, 99) < 33) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.data_byte     <= b;
      req_chan.start_channel <= st;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic feed(input logic [crlu_pkg::DATA_W-1:0] b);
      send_byte(b, lead_pending);
      lead_pending = 1'b0;
      phase_bytes++;
   endtask

   // Byte beats without a run may still be in flight, so keep waiting after the last run.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_runs != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_regs(input int m, input int w, input int h, input int s,
                               input int o);
      cur_mode = m;
      cur_w    = w;
      cur_h    = h;
      csr_write_en <= 1'b1;
      csr_index <= crlu_pkg::REG_MODE;
      csr_data  <= crlu_pkg::CSR_DATA_W'(m);
      @(negedge clock);
      csr_index <= crlu_pkg::REG_WIDTH;
      csr_data  <= crlu_pkg::CSR_DATA_W'(w);
      @(negedge clock);
      csr_index <= crlu_pkg::REG_HEIGHT;
      csr_data  <= crlu_pkg::CSR_DATA_W'(h);
      @(negedge clock);
      csr_index <= crlu_pkg::REG_STRIDE;
      csr_data  <= crlu_pkg::CSR_DATA_W'(s);
      @(negedge clock);
      csr_index <= crlu_pkg::REG_OFFSET;
      csr_data  <= crlu_pkg::CSR_DATA_W'(o);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // One random phase: most start a fresh channel, the rest carry on with the
   // counters of the previous one, sometimes under new register settings.
   task automatic random_phase();
      int w;
      int h;
      int total;
      int budget;
      int covered;
      int cnt;
      int k;
      lead_pending = ($urandom_range(0, 3) != 0);
      phase_bytes  = 0;
      if (lead_pending || $urandom_range(0, 1) == 1) begin
         case ($urandom_range(0, 9))
            0:       begin w = extreme_dim(); h = extreme_dim(); end
            1, 2:    begin w = $urandom_range(16, 64); h = $urandom_range(4, 10); end
            default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 6); end
         endcase
         program_regs($urandom_range(0, 1), w, h, $urandom_range(0, 7),
                      $urandom_range(0, 3));
      end
      total   = eff_dim(cur_w) * eff_dim(cur_h);
      budget  = $urandom_range(16, 120);
      covered = 0;
      while (covered < total && phase_bytes < budget) begin
         if ($urandom_range(0, 19) == 0) begin
            // A stray byte, sometimes restarting the channel, breaks the packets.
            send_byte(crlu_pkg::DATA_W'($urandom),
                      lead_pending || $urandom_range(0, 3) == 0);
            lead_pending = 1'b0;
            phase_bytes++;
         end else if (cur_mode == crlu_pkg::MODE_RAW) begin
            for (k = 0; k < eff_dim(cur_w) && phase_bytes < budget; k++)
               feed(crlu_pkg::DATA_W'($urandom));
            for (k = 0; k < (crlu_pkg::ROW_ALIGN - eff_dim(cur_w) % crlu_pkg::ROW_ALIGN)
                            % crlu_pkg::ROW_ALIGN; k++)
               feed(crlu_pkg::DATA_W'($urandom));
            covered += eff_dim(cur_w);
         end else if ($urandom_range(0, 1) == 1) begin
            cnt = $urandom_range(1, 127);
            feed(crlu_pkg::RLE_BIAS + crlu_pkg::DATA_W'(cnt));
            feed(crlu_pkg::DATA_W'($urandom));
            covered += cnt;
         end else begin
            case ($urandom_range(0, 9))
               0:       cnt = int'(crlu_pkg::RLE_BIAS);
               1:       cnt = 0;
               default: cnt = $urandom_range(1, 8);
            endcase
            feed(crlu_pkg::DATA_W'(cnt));
            for (k = 0; k < cnt; k++) feed(crlu_pkg::DATA_W'($urandom));
            covered += cnt;
         end
      end
      sent += phase_bytes;
      // A few trailing bytes, which the channel drops if it is already full.
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) send_byte(crlu_pkg::DATA_W'($urandom), 1'b0);
   endtask

   initial begin : stimulus
      reset                  = 1'b1;
      csr_write_en           = 1'b0;
      csr_index              = '0;
      csr_data               = '0;
      req_chan.valid         = 1'b0;
      req_chan.data_byte     = '0;
      req_chan.start_channel = 1'b0;
      calm                   = 1'b0;
      sent                   = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register defaults: a one-pixel channel clamps the repeated run.
      send_byte(8'd130, 1'b1);
      send_byte(8'h3C, 1'b0);
      drain();

      // Zero width and stride act as one, oversized height saturates, and the
      // offset is not below the stride. Count zero follows, then an unfinished literal of count 128.
      program_regs(crlu_pkg::MODE_RLE, 0, 2 ** crlu_pkg::HEIGHT_REG_W - 1, 0, 3);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'd129, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'd1, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(crlu_pkg::RLE_BIAS, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h00, 1'b0);
      drain();

      // Switching to raw mode in the middle of a literal keeps the counters.
      program_regs(crlu_pkg::MODE_RAW, 0, 2 ** crlu_pkg::HEIGHT_REG_W - 1, 0, 3);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h3C, 1'b0);
      drain();

      // Raw rows with padding; the channel fills and later bytes are dropped.
      program_regs(crlu_pkg::MODE_RAW, 3, 2, 4, 2);
      send_byte(8'h11, 1'b1);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'hEE, 1'b0);
      send_byte(8'h44, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h66, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte(8'h88, 1'b0);
      drain();

      // Oversized width saturates, zero height acts as one, stride saturates.
      program_regs(crlu_pkg::MODE_RLE, 2 ** crlu_pkg::WIDTH_REG_W - 1, 0, 7, 0);
      send_byte(8'd200, 1'b1);
      send_byte(8'h80, 1'b0);
      drain();

      while (sent < 1750) begin
         calm <= (sent >= 600 && sent < 1000);
         random_phase();
         drain();
      end

      repeat (16) @(negedge clock);
      if (mismatch_count == 0 && pending_runs == 0)
         $display("PASS channel_rle_unpacker_core");
      else
         $display("FAIL channel_rle_unpacker_core");
      $finish;
   end

endmodule
